/* src/dwps_pkg.sv */
// Package for the dyadic width pulse search: widths, defaults, register indices and the queue item type.
// No dependencies.
package dwps_pkg;

    localparam int DEF_MAX_WIDTHS = 8;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int VAL_W = 40;
    localparam int POS_W = 17;
    localparam logic [16:0] SQRT2_Q16 = 17'd92682;

    localparam logic [2:0] REG_MEAN = 3'd0;
    localparam logic [2:0] REG_ISTD = 3'd1;
    localparam logic [2:0] REG_THR = 3'd2;
    localparam logic [2:0] REG_WCNT = 3'd3;
    localparam logic [2:0] REG_BLK = 3'd4;

    typedef struct packed {
        logic [15:0] sample;
        logic [11:0] dm;
        logic [2:0] ds;
        logic last;
    } item_t;

endpackage

/* src/dwps_front.sv */
// Front end: accepts sample words and buffers them in a short queue.
// Depends on dwps_pkg.
module dwps_front
    import dwps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  item_t in_item,
    output logic q_valid,
    input  logic q_take,
    output item_t q_item
);

    item_t mem_reg [2];
    logic [1:0] cnt_reg;
    logic rd_reg;
    logic wr_reg;
    logic push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (q_take)
                rd_reg <= ~rd_reg;
            if (push && !q_take)
                cnt_reg <= cnt_reg + 2'd1;
            else if (!push && q_take)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= in_item;
    end

endmodule

/* src/dwps_back.sv */
// Back end: walks the width levels of one sample word, one level per step.
// Depends on dwps_pkg.
module dwps_back
    import dwps_pkg::*;
#(
    parameter int MAX_WIDTHS = DEF_MAX_WIDTHS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    output logic q_take,
    input  item_t q_item,
    input  logic [23:0] mean_level,
    input  logic [23:0] inverse_stdev,
    input  logic [15:0] snr_threshold,
    input  logic [3:0] width_count,
    input  logic [16:0] block_samples,
    output logic out_valid,
    input  logic out_ready,
    output logic [15:0] peak_snr,
    output logic [31:0] start_sample,
    output logic [11:0] trial_index,
    output logic [2:0] width_level,
    output logic last_result
);

    localparam int LW = $clog2(MAX_WIDTHS + 1);
    localparam int IW = (MAX_WIDTHS > 1) ? $clog2(MAX_WIDTHS) : 1;
    localparam logic [15:0] SMASK = (SAMPLE_BITS >= 16) ? 16'hFFFF
                                  : 16'((32'd1 << SAMPLE_BITS) - 32'd1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_SCL  = 7'b0000100,
        S_RT2  = 7'b0001000,
        S_UPD  = 7'b0010000,
        S_EMIT = 7'b0100000,
        S_END  = 7'b1000000
    } st_t;

    st_t st_reg;
    logic [VAL_W-1:0] hold_reg [MAX_WIDTHS];
    logic half_reg [MAX_WIDTHS];
    logic signed [16:0] best_reg [MAX_WIDTHS];
    logic [POS_W-1:0] boff_reg [MAX_WIDTHS];
    logic found_reg [MAX_WIDTHS];
    logic [POS_W-1:0] pos_reg [MAX_WIDTHS];
    logic [31:0] blk_reg;
    item_t it_reg;
    logic [VAL_W-1:0] x_reg;
    logic [LW-1:0] w_reg;
    logic [LW-1:0] lv_reg;
    logic neg_reg;
    logic [47:0] m_reg;
    logic [63:0] p_reg;
    logic signed [16:0] snr_reg;
    logic l0_reg;
    logic pend_reg;
    logic [15:0] cs_reg;
    logic [31:0] cst_reg;
    logic [2:0] cw_reg;
    logic sg_valid_reg;
    logic [15:0] sg_snr_reg;
    logic [31:0] sg_start_reg;
    logic [2:0] sg_width_reg;
    logic ov_reg;
    logic [15:0] os_reg;
    logic [31:0] oss_reg;
    logic [11:0] ot_reg;
    logic [2:0] ow_reg;
    logic ol_reg;

    logic [IW-1:0] wi;
    logic [16:0] size;
    logic [4:0] k;
    logic [VAL_W-1:0] mean_x;
    logic [VAL_W-1:0] diff;
    logic [POS_W-1:0] posn;
    logic signed [16:0] thr_s;
    logic out_free;
    logic load_mid;
    logic load_end;

    assign wi = w_reg[IW-1:0];
    assign size = (block_samples >> it_reg.ds) >> w_reg;
    assign k = {2'b0, it_reg.ds} + 5'(w_reg);
    assign mean_x = VAL_W'(mean_level);
    assign diff = (x_reg < mean_x) ? mean_x - x_reg : x_reg - mean_x;
    assign posn = pos_reg[wi] + 1'b1;
    assign thr_s = $signed({snr_threshold[15], snr_threshold});
    assign out_free = !ov_reg || out_ready;
    assign q_take = (st_reg == S_IDLE) && q_valid;
    assign load_mid = (st_reg == S_EMIT) && pend_reg && sg_valid_reg && out_free;
    assign load_end = (st_reg == S_END) && sg_valid_reg && out_free;

    assign out_valid = ov_reg;
    assign peak_snr = os_reg;
    assign start_sample = oss_reg;
    assign trial_index = ot_reg;
    assign width_level = ow_reg;
    assign last_result = ol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            os_reg <= '0;
            oss_reg <= '0;
            ot_reg <= '0;
            ow_reg <= '0;
            ol_reg <= 1'b0;
        end
        else if (load_mid || load_end)
        begin
            ov_reg <= 1'b1;
            os_reg <= sg_snr_reg;
            oss_reg <= sg_start_reg;
            ot_reg <= it_reg.dm;
            ow_reg <= sg_width_reg;
            ol_reg <= load_end;
        end
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            blk_reg <= '0;
            pend_reg <= 1'b0;
            sg_valid_reg <= 1'b0;
            l0_reg <= 1'b0;
            w_reg <= '0;
            lv_reg <= '0;
            for (int i = 0; i < MAX_WIDTHS; i++)
            begin
                hold_reg[i] <= '0;
                half_reg[i] <= 1'b0;
                best_reg[i] <= '0;
                boff_reg[i] <= '0;
                found_reg[i] <= 1'b0;
                pos_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (st_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        it_reg <= q_item;
                        x_reg <= VAL_W'(q_item.sample & SMASK) << 8;
                        w_reg <= '0;
                        l0_reg <= 1'b0;
                        pend_reg <= 1'b0;
                        lv_reg <= (32'(width_count) > MAX_WIDTHS) ? LW'(MAX_WIDTHS)
                                                             : LW'(width_count);
                        if (width_count == 4'd0)
                            st_reg <= S_END;
                        else
                            st_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    neg_reg <= x_reg < mean_x;
                    p_reg <= 64'(diff) * 64'(inverse_stdev);
                    st_reg <= S_SCL;
                end
                S_SCL:
                begin
                    m_reg <= ((p_reg > (64'd1 << 40)) ? 48'd1 << 40 : p_reg[47:0]);
                    st_reg <= S_RT2;
                end
                S_RT2:
                begin
                    logic [63:0] t;
                    logic [63:0] u;
                    t = 64'(m_reg) << k[4:1];
                    if (k[0])
                        u = (t * 64'(SQRT2_Q16)) >> 32;
                    else
                        u = t >> 16;
                    if (u > 64'd65535)
                        u = 64'd65535;
                    snr_reg <= neg_reg ? -$signed({1'b0, u[15:0]}) : $signed({1'b0, u[15:0]});
                    st_reg <= S_UPD;
                end
                S_UPD:
                begin
                    logic qual;
                    logic nf;
                    logic signed [16:0] nb;
                    logic [POS_W-1:0] no;
                    qual = snr_reg > thr_s && snr_reg > 0
                           && (!found_reg[wi] || snr_reg > best_reg[wi]);
                    nf = found_reg[wi] || qual;
                    nb = qual ? snr_reg : best_reg[wi];
                    no = qual ? pos_reg[wi] : boff_reg[wi];
                    pend_reg <= (size != 17'd0) && (posn >= size) && nf;
                    cs_reg <= 16'(nb);
                    cst_reg <= blk_reg * 32'(block_samples) + (32'(no) << w_reg);
                    cw_reg <= 3'(w_reg);
                    if (size != 17'd0)
                    begin
                        if (posn >= size)
                        begin
                            found_reg[wi] <= 1'b0;
                            best_reg[wi] <= '0;
                            boff_reg[wi] <= '0;
                            pos_reg[wi] <= '0;
                            if (w_reg == '0)
                                l0_reg <= 1'b1;
                        end
                        else
                        begin
                            found_reg[wi] <= nf;
                            best_reg[wi] <= nb;
                            boff_reg[wi] <= no;
                            pos_reg[wi] <= posn;
                        end
                    end
                    if (32'(w_reg) + 32'd1 < 32'(lv_reg))
                    begin
                        if (half_reg[wi])
                        begin
                            x_reg <= (hold_reg[wi] + x_reg) >> 1;
                            half_reg[wi] <= 1'b0;
                            hold_reg[wi] <= '0;
                        end
                        else
                        begin
                            hold_reg[wi] <= x_reg;
                            half_reg[wi] <= 1'b1;
                        end
                    end
                    st_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    logic cont;
                    cont = (32'(w_reg) + 32'd1 < 32'(lv_reg)) && !half_reg[wi];
                    if (!pend_reg || !sg_valid_reg || out_free)
                    begin
                        if (pend_reg)
                        begin
                            sg_valid_reg <= 1'b1;
                            sg_snr_reg <= cs_reg;
                            sg_start_reg <= cst_reg;
                            sg_width_reg <= cw_reg;
                        end
                        pend_reg <= 1'b0;
                        if (cont)
                        begin
                            w_reg <= w_reg + 1'b1;
                            st_reg <= S_MUL;
                        end
                        else
                            st_reg <= S_END;
                    end
                end
                S_END:
                begin
                    if (!sg_valid_reg || out_free)
                    begin
                        sg_valid_reg <= 1'b0;
                        blk_reg <= it_reg.last ? '0 : (l0_reg ? blk_reg + 32'd1 : blk_reg);
                        if (it_reg.last)
                        begin
                            for (int i = 0; i < MAX_WIDTHS; i++)
                            begin
                                hold_reg[i] <= '0;
                                half_reg[i] <= 1'b0;
                                best_reg[i] <= '0;
                                boff_reg[i] <= '0;
                                found_reg[i] <= 1'b0;
                                pos_reg[i] <= '0;
                            end
                        end
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* src/dwps_cfg.sv */
// Configuration registers of the pulse search.
// Depends on dwps_pkg.
module dwps_cfg
    import dwps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [23:0] cfg_data,
    output logic [23:0] mean_level,
    output logic [23:0] inverse_stdev,
    output logic [15:0] snr_threshold,
    output logic [3:0] width_count,
    output logic [16:0] block_samples
);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_level <= '0;
            inverse_stdev <= 24'd65536;
            snr_threshold <= 16'd1536;
            width_count <= 4'd8;
            block_samples <= 17'd4096;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MEAN: mean_level <= cfg_data;
                REG_ISTD: inverse_stdev <= cfg_data;
                REG_THR:  snr_threshold <= cfg_data[15:0];
                REG_WCNT: width_count <= cfg_data[3:0];
                REG_BLK:  block_samples <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

endmodule

/* src/dyadic_width_pulse_search_top.sv */
// Channel  | dir | handshake          | fields
// in       | in  | in_valid/in_ready  | sample_value dm_index downsample_log2 last_of_series
// out      | out | out_valid/out_ready| peak_snr start_sample trial_index width_level last_result
// cfg      | in  | cfg_we             | cfg_index cfg_data
// Each word walks up to min(width_count, MAX_WIDTHS) levels through the shared multiply and
// scale path; a word with a width_count of zero goes straight from idle to the end state.
// Reset is asynchronous and clears the control, search and output state, but not the data holding registers.
// A candidate waits in a staging register until the next candidate or the end of its word;
// the walk stalls only when that handoff finds the result register still full.
// A two-word queue lets the input run ahead while the back end stalls.
module dyadic_width_pulse_search_top
    import dwps_pkg::*;
#(
    parameter int MAX_WIDTHS = DEF_MAX_WIDTHS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [23:0] cfg_data,
    input  logic in_valid,
    output logic in_ready,
    input  logic [15:0] sample_value,
    input  logic [11:0] dm_index,
    input  logic [2:0] downsample_log2,
    input  logic last_of_series,
    output logic out_valid,
    input  logic out_ready,
    output logic [15:0] peak_snr,
    output logic [31:0] start_sample,
    output logic [11:0] trial_index,
    output logic [2:0] width_level,
    output logic last_result
);

    logic [23:0] mean_level;
    logic [23:0] inverse_stdev;
    logic [15:0] snr_threshold;
    logic [3:0] width_count;
    logic [16:0] block_samples;
    item_t in_item;
    item_t q_item;
    logic q_valid;
    logic q_take;

    assign in_item = '{sample: sample_value, dm: dm_index, ds: downsample_log2,
                       last: last_of_series};

    dwps_cfg u_cfg (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
        .mean_level, .inverse_stdev, .snr_threshold, .width_count, .block_samples
    );

    dwps_front u_front (
        .clk, .rst_n, .in_valid, .in_ready, .in_item, .q_valid, .q_take, .q_item
    );

    dwps_back #(.MAX_WIDTHS(MAX_WIDTHS), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .clk, .rst_n, .q_valid, .q_take, .q_item,
        .mean_level, .inverse_stdev, .snr_threshold, .width_count, .block_samples,
        .out_valid, .out_ready, .peak_snr, .start_sample, .trial_index,
        .width_level, .last_result
    );

endmodule

/* src/dwps_checker.sv */
// Port-level checks for the pulse search top level, attached by bind.
// Depends on dyadic_width_pulse_search_top.
module dwps_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic [15:0] peak_snr,
    input logic [2:0] width_level
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(peak_snr))
        else $error("result word changed while stalled");

    a_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> peak_snr != 16'd0)
        else $error("candidate with zero snr");

    a_lvl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(width_level))
        else $error("width level changed while stalled");

endmodule

bind dyadic_width_pulse_search_top dwps_checker u_chk (
    .clk, .rst_n, .out_valid, .out_ready, .peak_snr, .width_level
);

/* tb/sv/dyadic_width_pulse_search_top_tb.sv */
// Self-checking testbench for dyadic_width_pulse_search_top: directed and random sample
// series, predicted in SystemVerilog and compared word by word. Depends on dwps_pkg.
`timescale 1ns / 1ps

module dyadic_width_pulse_search_top_tb;
    import dwps_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 200;

    typedef struct {
        logic [15:0] snr;
        logic [31:0] start;
        logic [11:0] trial;
        logic [2:0] width;
        logic last;
    } cand_t;

    typedef struct {
        logic [15:0] sample;
        logic [11:0] dm;
        logic [2:0] ds;
        logic last;
        bit typed;
        logic [15:0] snr;
        logic [31:0] start;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [23:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [15:0] sample_value;
    logic [11:0] dm_index;
    logic [2:0] downsample_log2;
    logic last_of_series;
    logic out_valid;
    logic out_ready;
    logic [15:0] peak_snr;
    logic [31:0] start_sample;
    logic [11:0] trial_index;
    logic [2:0] width_level;
    logic last_result;

    cand_t cand_q[$];
    int errors = 0;
    int cycles = 0;
    bit no_gaps = 0;

    logic [23:0] m_mean;
    logic [23:0] m_istd;
    logic [15:0] m_thr;
    logic [3:0] m_wcnt;
    logic [16:0] m_blk;
    logic [63:0] p_hold[8];
    bit p_half[8];
    int b_val[8];
    logic [16:0] b_off[8];
    bit b_found[8];
    logic [16:0] l_pos[8];
    logic [31:0] blk_num;

    row_t rows[22];

    dyadic_width_pulse_search_top u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .sample_value(sample_value), .dm_index(dm_index),
        .downsample_log2(downsample_log2), .last_of_series(last_of_series),
        .out_valid(out_valid), .out_ready(out_ready), .peak_snr(peak_snr),
        .start_sample(start_sample), .trial_index(trial_index),
        .width_level(width_level), .last_result(last_result)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** dyadic_width_pulse_search_top: FAILED **");
            $finish;
        end
    end

    task automatic clear_search();
        for (int i = 0; i < 8; i++)
        begin
            p_hold[i] = 0;
            p_half[i] = 0;
            b_val[i] = 0;
            b_off[i] = 0;
            b_found[i] = 0;
            l_pos[i] = 0;
        end
        blk_num = 0;
    endtask

    function automatic int scaled_snr(logic [63:0] x, int k);
        logic [63:0] m;
        bit neg;
        neg = x < {40'd0, m_mean};
        m = neg ? {40'd0, m_mean} - x : x - {40'd0, m_mean};
        m = m * {40'd0, m_istd};
        if (m > (64'd1 << 40)) m = 64'd1 << 40;
        m = m << (k >> 1);
        if (k % 2 == 1) m = (m * 64'd92682) >> 16;
        m = m >> 16;
        if (m > 64'd65535) m = 64'd65535;
        return neg ? -int'(m) : int'(m);
    endfunction

    task automatic predict_word(logic [15:0] s, logic [11:0] dm, logic [2:0] d, logic lst);
        logic [63:0] x;
        logic [16:0] base;
        logic [16:0] size;
        int levels;
        int thr;
        int snr;
        int n;
        bit have;
        bit l0_done;
        cand_t c;
        x = {40'd0, s, 8'd0};
        levels = (m_wcnt > 8) ? 8 : m_wcnt;
        thr = int'($signed(m_thr));
        base = m_blk >> d;
        have = 1;
        l0_done = 0;
        n = 0;
        for (int w = 0; w < levels && have; w++)
        begin
            size = base >> w;
            if (size != 0)
            begin
                snr = scaled_snr(x, w + d);
                if (snr > thr && snr > 0 && (!b_found[w] || snr > b_val[w]))
                begin
                    b_found[w] = 1;
                    b_val[w] = snr;
                    b_off[w] = l_pos[w];
                end
                l_pos[w] = l_pos[w] + 17'd1;
                if (l_pos[w] >= size)
                begin
                    if (b_found[w])
                    begin
                        c.snr = b_val[w][15:0];
                        c.start = blk_num * {15'd0, m_blk} + ({15'd0, b_off[w]} << w);
                        c.trial = dm;
                        c.width = w[2:0];
                        c.last = 0;
                        cand_q = {cand_q, c};
                        n++;
                    end
                    b_found[w] = 0;
                    b_val[w] = 0;
                    b_off[w] = 0;
                    l_pos[w] = 0;
                    if (w == 0) l0_done = 1;
                end
            end
            if (w + 1 < levels)
            begin
                if (p_half[w])
                begin
                    x = (p_hold[w] + x) >> 1;
                    p_half[w] = 0;
                    p_hold[w] = 0;
                end
                else
                begin
                    p_hold[w] = x;
                    p_half[w] = 1;
                    have = 0;
                end
            end
        end
        if (l0_done) blk_num = blk_num + 1;
        if (n > 0) cand_q[$].last = 1;
        if (lst) clear_search();
    endtask

    task automatic send_word(logic [15:0] s, logic [11:0] dm, logic [2:0] d, logic lst);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        sample_value <= s;
        dm_index <= dm;
        downsample_log2 <= d;
        last_of_series <= lst;
        do @(posedge clk); while (!in_ready);
        predict_word(s, dm, d, lst);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (cand_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_regs(logic [23:0] mean, logic [23:0] istd, logic [15:0] thr,
                            logic [3:0] wcnt, logic [16:0] blk);
        logic [23:0] vals[5];
        logic [2:0] idx[5];
        vals = '{mean, istd, {8'd0, thr}, {20'd0, wcnt}, {7'd0, blk}};
        idx = '{REG_MEAN, REG_ISTD, REG_THR, REG_WCNT, REG_BLK};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we <= 1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 0;
        m_mean = mean;
        m_istd = istd;
        m_thr = thr;
        m_wcnt = wcnt;
        m_blk = blk;
    endtask

    initial
    begin
        int stall;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                out_ready <= 0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1;
            do @(posedge clk); while (!out_valid);
            if (cand_q.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected word snr=%0d start=%0d", peak_snr,
                                           start_sample);
            end
            else if (peak_snr !== cand_q[0].snr || start_sample !== cand_q[0].start ||
                     trial_index !== cand_q[0].trial || width_level !== cand_q[0].width ||
                     last_result !== cand_q[0].last)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                             cand_q[0].snr, cand_q[0].start, cand_q[0].trial,
                             cand_q[0].width, cand_q[0].last, peak_snr, start_sample,
                             trial_index, width_level, last_result);
                void'(cand_q.pop_front());
            end
            else
                void'(cand_q.pop_front());
        end
    end

    initial
    begin
        int len;
        int nitems;
        logic [11:0] dm;
        logic [2:0] d;
        logic [15:0] s;
        logic [23:0] mean;
        logic [23:0] istd;
        logic [15:0] thr;
        logic [3:0] wcnt;
        logic [16:0] blk;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        in_valid = 0;
        sample_value = 0;
        dm_index = 0;
        downsample_log2 = 0;
        last_of_series = 0;
        m_mean = 0;
        m_istd = 24'd65536;
        m_thr = 16'd1536;
        m_wcnt = 4'd8;
        m_blk = 17'd4096;
        clear_search();
        rows = '{
            '{16'd5, 12'd0, 3'd0, 1'b0, 1'b1, 16'd1280, 32'd0},
            '{16'd65535, 12'd4095, 3'd0, 1'b0, 1'b1, 16'd65535, 32'd1},
            '{16'd0, 12'd1, 3'd0, 1'b0, 1'b0, 16'd0, 32'd0},
            '{16'd1, 12'd2, 3'd1, 1'b0, 1'b0, 16'd0, 32'd0},
            '{16'd7, 12'd3, 3'd0, 1'b0, 1'b1, 16'd1792, 32'd3},
            '{16'd9, 12'd5, 3'd7, 1'b1, 1'b0, 16'd0, 32'd0},
            '{16'd2, 12'd6, 3'd0, 1'b0, 1'b1, 16'd512, 32'd0},
            '{16'd43690, 12'd2730, 3'd2, 1'b0, 1'b0, 16'd0, 32'd0},
            '{16'd21845, 12'd1365, 3'd0, 1'b0, 1'b0, 16'd0, 32'd0},
            '{16'd100, 12'd7, 3'd0, 1'b1, 1'b0, 16'd0, 32'd0},
            '{16'd65535, 12'd9, 3'd0, 1'b0, 1'b0, 16'd0, 32'd0},
            '{16'd0, 12'd9, 3'd0, 1'b0, 1'b0, 16'd0, 32'd0},
            '{16'd65535, 12'd9, 3'd0, 1'b0, 1'b0, 16'd0, 32'd0},
            '{16'd12345, 12'd9, 3'd0, 1'b0, 1'b0, 16'd0, 32'd0},
            '{16'd65535, 12'd9, 3'd1, 1'b0, 1'b0, 16'd0, 32'd0},
            '{16'd1, 12'd9, 3'd1, 1'b0, 1'b0, 16'd0, 32'd0},
            '{16'd30000, 12'd9, 3'd1, 1'b0, 1'b0, 16'd0, 32'd0},
            '{16'd65535, 12'd9, 3'd1, 1'b0, 1'b0, 16'd0, 32'd0},
            '{16'd40000, 12'd4000, 3'd3, 1'b0, 1'b0, 16'd0, 32'd0},
            '{16'd500, 12'd4000, 3'd4, 1'b0, 1'b0, 16'd0, 32'd0},
            '{16'd65535, 12'd4000, 3'd0, 1'b0, 1'b0, 16'd0, 32'd0},
            '{16'd32768, 12'd4000, 3'd0, 1'b1, 1'b0, 16'd0, 32'd0}
        };
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        set_regs(24'd0, 24'd65536, 16'd0, 4'd1, 17'd1);
        for (int i = 0; i < 22; i++)
        begin
            if (i == 10)
            begin
                drain();
                set_regs(24'hFFFFFF, 24'hFFFFFF, 16'h8000, 4'd8, 17'd8);
            end
            send_word(rows[i].sample, rows[i].dm, rows[i].ds, rows[i].last);
            if (rows[i].typed)
            begin
                cand_q[$].snr = rows[i].snr;
                cand_q[$].start = rows[i].start;
                cand_q[$].trial = rows[i].dm;
                cand_q[$].width = 3'd0;
                cand_q[$].last = 1'b1;
            end
        end

        for (int p = 0; p < 12; p++)
        begin
            drain();
            no_gaps = (p % 4 == 3);
            mean = (p == 1) ? 24'hFFFFFF : (p == 2) ? 24'd0
                 : 24'($urandom_range(0, 24'hFFFFFF));
            if ($urandom_range(0, 2) == 0 && p > 2) mean = 24'($urandom_range(0, 65535) << 8);
            istd = (p == 1) ? 24'hFFFFFF : (p == 4) ? 24'd0
                 : 24'($urandom_range(0, 24'hFFFFFF));
            if ($urandom_range(0, 2) == 0) istd = 24'($urandom_range(0, 131072));
            thr = (p == 2) ? 16'h7FFF : (p == 5) ? 16'h8000 : 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 1) == 0) thr = 16'($urandom_range(0, 2048));
            wcnt = (p == 3) ? 4'd0 : (p == 6) ? 4'd15 : (p == 7) ? 4'd1
                 : 4'($urandom_range(1, 8));
            blk = (p == 8) ? 17'd0 : (p == 9) ? 17'd65536 : (p == 10) ? 17'd3
                : 17'd1 << $urandom_range(0, 5);
            set_regs(mean, istd, thr, wcnt, blk);
            nitems = (blk > 64) ? 12 : 20;
            while (nitems > 0)
            begin
                len = $urandom_range(1, 12);
                dm = 12'($urandom_range(0, 4095));
                d = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                               : 3'($urandom_range(0, 1));
                for (int k = 0; k < len && nitems > 0; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        dm = 12'($urandom_range(0, 4095));
                        d = 3'($urandom_range(0, 7));
                    end
                    s = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
                    send_word(s, dm, d, (k == len - 1) || ($urandom_range(0, 19) == 0));
                    nitems--;
                end
            end
        end

        drain();
        if (errors == 0 && cand_q.size() == 0)
            $display("** dyadic_width_pulse_search_top: PASSED **");
        else
            $display("** dyadic_width_pulse_search_top: FAILED **");
        $finish;
    end

endmodule
